@@ src/mbce_pkg.sv @@
package mbce_pkg;

	localparam int LANES      = 8;
	localparam int LANE_IDX_W = 3;
	localparam int BYTE_W     = 8;
	localparam int COORD_W    = 9;
	localparam int ROW_W      = 10;
	localparam int ADDR_W     = 15;
	localparam int COLOR_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int PAGE_W     = 5;
	localparam int TDATA_W    = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X    = 3'd0,
		CFG_ORIGIN_Y    = 3'd1,
		CFG_RECT_WIDTH  = 3'd2,
		CFG_RECT_HEIGHT = 3'd3,
		CFG_FORE_COLOR  = 3'd4,
		CFG_BACK_COLOR  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic               valid;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
	} lane_res_t;

	function automatic logic [COLOR_W-1:0] swap_bytes(input logic [COLOR_W-1:0] c);
		return {c[7:0], c[15:8]};
	endfunction

endpackage

@@ src/mbce_lane.sv @@
module mbce_lane #(
	parameter int SCREEN_WIDTH = 128,
	parameter int LANE_IDX     = 0
) (
	input  logic [mbce_pkg::COORD_W-1:0] row0,
	input  logic [mbce_pkg::COORD_W-1:0] row_end,
	input  logic [mbce_pkg::COORD_W-1:0] col,
	input  logic                         col_ok,
	input  logic                         pix_bit,
	input  logic [mbce_pkg::COLOR_W-1:0] fg,
	input  logic [mbce_pkg::COLOR_W-1:0] bg,
	output mbce_pkg::lane_res_t          res
);

	localparam logic [7:0] SW8 = 8'(SCREEN_WIDTH);

	logic [mbce_pkg::ROW_W-1:0]   row;
	logic [mbce_pkg::ROW_W+7:0]   prod;
	logic [mbce_pkg::ROW_W+8:0]   sum;

	assign row  = mbce_pkg::ROW_W'(row0) + mbce_pkg::ROW_W'(LANE_IDX);
	assign prod = (mbce_pkg::ROW_W+8)'(row) * (mbce_pkg::ROW_W+8)'(SW8);
	assign sum  = (mbce_pkg::ROW_W+9)'(prod) + (mbce_pkg::ROW_W+9)'(col);

	assign res.valid = col_ok && (row < {1'b0, row_end});
	assign res.addr  = sum[mbce_pkg::ADDR_W-1:0];
	assign res.color = pix_bit ? fg : bg;

endmodule

@@ src/mbce_merge.sv @@
module mbce_merge (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       load,
	input  mbce_pkg::lane_res_t [mbce_pkg::LANES-1:0]  lanes,
	output logic                                       free,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	output logic [mbce_pkg::TDATA_W-1:0]               m_tdata,
	output logic                                       m_tlast
);

	logic [mbce_pkg::LANES-1:0]   mask_s2;
	logic [mbce_pkg::ADDR_W-1:0]  addr_s2  [mbce_pkg::LANES];
	logic [mbce_pkg::COLOR_W-1:0] color_s2 [mbce_pkg::LANES];
	logic [mbce_pkg::LANES-1:0]   remain;
	logic [mbce_pkg::LANE_IDX_W-1:0] sel;
	logic [mbce_pkg::LANES-1:0]   new_mask;

	// lowest pending lane goes first, i.e. top row first
	always_comb begin
		sel = '0;
		for (int b = mbce_pkg::LANES - 1; b >= 0; b--) begin
			if (mask_s2[b]) sel = mbce_pkg::LANE_IDX_W'(b);
		end
	end

	assign remain   = mask_s2 & (mask_s2 - mbce_pkg::LANES'(1));
	assign m_tvalid = |mask_s2;
	assign m_tlast  = (remain == '0);
	assign free     = !m_tvalid || (m_tready && m_tlast);
	assign m_tdata  = {1'b0, color_s2[sel], addr_s2[sel]};

	always_comb begin
		for (int b = 0; b < mbce_pkg::LANES; b++) begin
			new_mask[b] = lanes[b].valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
		end else if (free) begin
			mask_s2 <= load ? new_mask : '0;
		end else if (m_tready) begin
			mask_s2 <= remain;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			for (int b = 0; b < mbce_pkg::LANES; b++) begin
				addr_s2[b]  <= lanes[b].addr;
				color_s2[b] <= lanes[b].color;
			end
		end
	end

endmodule

@@ src/mono_bitmap_color_expand.sv @@
// Monochrome bitmap color expander. Each input item is one bitmap byte holding
// eight vertical pixels of one column (bit 0 on top); bytes arrive page by page,
// all columns of a page before the next. Every pixel that lies inside both the
// destination rectangle and the screen becomes one output item: tdata carries the
// linear framebuffer address (row * SCREEN_WIDTH + column, low 15 bits) and the
// byte-swapped foreground or background color, and tlast marks the final write of
// the byte. Clipped pixels give nothing; a fully clipped byte gives no item but
// still advances the column/page counters. Eight lanes evaluate the bits of a byte
// in parallel and a merge stage sends their writes one per cycle while m_tready
// is high. The next byte is taken while the current one drains, so the output
// stays busy back to back. A write to any listed config register clears the
// counters; write config only while the block is idle.
module mono_bitmap_color_expand #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 160
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_we,
	input  logic [mbce_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mbce_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mbce_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] bitmap_byte
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mbce_pkg::TDATA_W-1:0]      m_tdata,   // [14:0] pixel_addr,
	                                                     // [30:15] pixel_color, [31] zero
	output logic                              m_tlast    // last_of_byte
);

	localparam logic [mbce_pkg::COORD_W-1:0] SW9 = mbce_pkg::COORD_W'(SCREEN_WIDTH);
	localparam logic [mbce_pkg::COORD_W-1:0] SH9 = mbce_pkg::COORD_W'(SCREEN_HEIGHT);

	// configuration registers
	logic [7:0]                    origin_x_q, origin_y_q, rect_width_q, rect_height_q;
	logic [mbce_pkg::COLOR_W-1:0]  fore_color_q, back_color_q;

	// position of the next byte inside the bitmap
	logic [7:0]                    column_q;
	logic [mbce_pkg::PAGE_W-1:0]   page_q;

	// stage 1: accepted byte with its screen position
	logic                          valid_s1;
	logic [7:0]                    bits_s1;
	logic [mbce_pkg::COORD_W-1:0]  col_s1;
	logic [mbce_pkg::COORD_W-1:0]  row0_s1;
	logic                          col_ok_s1;

	logic                          accept;
	logic                          merge_free;
	logic                          cfg_hit;
	logic [mbce_pkg::COORD_W-1:0]  col, col_lim, col_end, row_lim, row_end, row0;
	logic [8:0]                    col_next;
	logic [mbce_pkg::COLOR_W-1:0]  fg, bg;

	mbce_pkg::lane_res_t [mbce_pkg::LANES-1:0] lanes;

	assign s_tready = !valid_s1 || merge_free;
	assign accept   = s_tvalid && s_tready;

	// clip limits: full-width sums, never wrapped
	assign col     = {1'b0, origin_x_q} + {1'b0, column_q};
	assign col_lim = {1'b0, origin_x_q} + {1'b0, rect_width_q};
	assign col_end = (col_lim < SW9) ? col_lim : SW9;
	assign row_lim = {1'b0, origin_y_q} + {1'b0, rect_height_q};
	assign row_end = (row_lim < SH9) ? row_lim : SH9;
	assign row0    = {1'b0, origin_y_q} + {1'b0, page_q, 3'b000};

	assign col_next = {1'b0, column_q} + 9'd1;

	assign fg = mbce_pkg::swap_bytes(fore_color_q);
	assign bg = mbce_pkg::swap_bytes(back_color_q);

	always_comb begin
		case (cfg_index)
			mbce_pkg::CFG_ORIGIN_X,
			mbce_pkg::CFG_ORIGIN_Y,
			mbce_pkg::CFG_RECT_WIDTH,
			mbce_pkg::CFG_RECT_HEIGHT,
			mbce_pkg::CFG_FORE_COLOR,
			mbce_pkg::CFG_BACK_COLOR: cfg_hit = cfg_we;
			default:                  cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			rect_width_q  <= '0;
			rect_height_q <= '0;
			fore_color_q  <= '0;
			back_color_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mbce_pkg::CFG_ORIGIN_X:    origin_x_q    <= cfg_data[7:0];
				mbce_pkg::CFG_ORIGIN_Y:    origin_y_q    <= cfg_data[7:0];
				mbce_pkg::CFG_RECT_WIDTH:  rect_width_q  <= cfg_data[7:0];
				mbce_pkg::CFG_RECT_HEIGHT: rect_height_q <= cfg_data[7:0];
				mbce_pkg::CFG_FORE_COLOR:  fore_color_q  <= cfg_data;
				mbce_pkg::CFG_BACK_COLOR:  back_color_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance column per byte, wrap to the next page at the bitmap width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			page_q   <= '0;
		end else if (cfg_hit) begin
			column_q <= '0;
			page_q   <= '0;
		end else if (accept) begin
			if (col_next >= {1'b0, rect_width_q}) begin
				column_q <= '0;
				page_q   <= page_q + mbce_pkg::PAGE_W'(1);
			end else begin
				column_q <= col_next[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bits_s1   <= s_tdata;
			col_s1    <= col;
			row0_s1   <= row0;
			col_ok_s1 <= (col < col_end);
		end
	end

	// one lane per bit of the byte
	for (genvar b = 0; b < mbce_pkg::LANES; b++) begin : g_lane
		mbce_lane #(
			.SCREEN_WIDTH (SCREEN_WIDTH),
			.LANE_IDX     (b)
		) u_lane (
			.row0    (row0_s1),
			.row_end (row_end),
			.col     (col_s1),
			.col_ok  (col_ok_s1),
			.pix_bit (bits_s1[b]),
			.fg      (fg),
			.bg      (bg),
			.res     (lanes[b])
		);
	end

	mbce_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (valid_s1),
		.lanes    (lanes),
		.free     (merge_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
